@@ rtl/stpg_pkg.sv @@
// Shared types and constants for the trapezoid step/direction generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package stpg_pkg;

  // Command codes carried by the opcode field
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Motion phase codes (state of the back end)
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_CRUISE = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  // Register indexes on the APB port (byte address = 4 * index)
  localparam logic [2:0] REG_ACCEL_STEPS = 3'd0;
  localparam logic [2:0] REG_RAMP_START  = 3'd1;
  localparam logic [2:0] REG_RAMP_END    = 3'd2;
  localparam logic [2:0] REG_RAMP_DELTA  = 3'd3;
  localparam logic [2:0] REG_CRUISE_HIGH = 3'd4;
  localparam logic [2:0] REG_CRUISE_LOW  = 3'd5;

  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_W      = 20;
  localparam int unsigned DELTA_W    = 10;
  localparam int unsigned TOTAL_W    = 24;

  localparam logic [REG_W-1:0]   RST_ACCEL_STEPS = 20'd9000;
  localparam logic [REG_W-1:0]   RST_RAMP_START  = 20'd28500;
  localparam logic [REG_W-1:0]   RST_RAMP_END    = 20'd1500;
  localparam logic [DELTA_W-1:0] RST_RAMP_DELTA  = 10'd3;
  localparam logic [REG_W-1:0]   RST_CRUISE_HIGH = 20'd1500;
  localparam logic [REG_W-1:0]   RST_CRUISE_LOW  = 20'd1500;

  typedef struct packed {
    logic [REG_W-1:0]   accel_steps;
    logic [REG_W-1:0]   ramp_start;
    logic [REG_W-1:0]   ramp_end;
    logic [DELTA_W-1:0] ramp_delta;
    logic [REG_W-1:0]   cruise_high;
    logic [REG_W-1:0]   cruise_low;
  } stpg_cfg_t;

  typedef struct packed {
    logic       step_level;
    logic       dir_level;
    logic       busy_res;
    logic [1:0] phase;
    logic       move_done;
    logic       start_ignored;
  } stpg_res_t;

endpackage

`default_nettype wire

@@ rtl/stpg_front.sv @@
// Front end: takes command transfers, works out the cruise length of a start.
// Depends on stpg_pkg; feeds the command queue.
`default_nettype none

module stpg_front import stpg_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   opcode_i,
  input  wire logic                   direction_i,
  input  wire logic [TOTAL_W-1:0]     step_total_i,
  input  wire stpg_cfg_t              cfg_i,
  output logic                        q_push_o,
  output logic [COUNT_WIDTH+1:0]      q_data_o,
  input  wire logic                   q_full_i
);

  localparam logic [32:0] CountMax = 33'({COUNT_WIDTH{1'b1}});

  logic [32:0]            twice;
  logic [32:0]            total_ext;
  logic [32:0]            diff;
  logic [COUNT_WIDTH-1:0] cruise;

  always_comb begin
    twice     = 33'(cfg_i.accel_steps) << 1;
    total_ext = 33'(step_total_i);
    diff      = (total_ext > twice) ? (total_ext - twice) : 33'd0;
    cruise    = (diff > CountMax) ? {COUNT_WIDTH{1'b1}} : diff[COUNT_WIDTH-1:0];
  end

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;
  // A tick carries no count; only a start needs the cruise length.
  assign q_data_o   = {opcode_i, direction_i,
                       (opcode_i == OP_START) ? cruise : {COUNT_WIDTH{1'b0}}};

endmodule

`default_nettype wire

@@ rtl/stpg_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on stpg_pkg for nothing but house style; flop storage.
`default_nettype none

module stpg_queue import stpg_pkg::*; #(
  parameter int unsigned WIDTH = 26
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stpg_back.sv @@
// Back end: profile state machine that runs one queued command per cycle while the
// result register is free or being taken, with the result register on the output side. Depends on stpg_pkg.
`default_nettype none

module stpg_back import stpg_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24,
  parameter int unsigned TIME_WIDTH  = 20
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire stpg_cfg_t              cfg_i,
  input  wire logic                   q_valid_i,
  input  wire logic [COUNT_WIDTH+1:0] q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output stpg_res_t                   res_o
);

  localparam logic [32:0] CountMax = 33'({COUNT_WIDTH{1'b1}});
  localparam logic [32:0] TimeMax  = 33'({TIME_WIDTH{1'b1}});

  function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [REG_W-1:0] v);
    logic [TIME_WIDTH-1:0] t;
    t = TIME_WIDTH'(v);
    return (t == '0) ? TIME_WIDTH'(1) : t;
  endfunction

  function automatic logic [TIME_WIDTH-1:0] clamp_half(input logic [TIME_WIDTH-1:0] v);
    return (v == '0) ? TIME_WIDTH'(1) : v;
  endfunction

  logic [1:0]             phase_q, phase_d;
  logic                   pin_q, pin_d;
  logic                   dir_q, dir_d;
  logic [TIME_WIDTH-1:0]  timer_q, timer_d;
  logic [TIME_WIDTH-1:0]  ramp_q, ramp_d;
  logic [COUNT_WIDTH-1:0] steps_q, steps_d;
  logic [COUNT_WIDTH-1:0] cruise_q, cruise_d;
  logic                   out_valid_q;
  stpg_res_t              res_q, res_d;

  logic                   e_op, e_dir;
  logic [COUNT_WIDTH-1:0] e_cruise;
  logic [COUNT_WIDTH-1:0] acc_sat;
  logic [32:0]            acc_ext;
  logic [TIME_WIDTH-1:0]  t_dec;
  logic [COUNT_WIDTH-1:0] s_dec;
  logic [32:0]            ramp_ext, delta_ext, r_down, r_up;
  logic [TIME_WIDTH-1:0]  ramp_upd;
  logic                   do_enter;
  logic [1:0]             enter_ph;
  logic                   done, ignored;

  assign {e_op, e_dir, e_cruise} = q_data_i;
  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    acc_ext  = 33'(cfg_i.accel_steps);
    acc_sat  = (acc_ext > CountMax) ? {COUNT_WIDTH{1'b1}} : acc_ext[COUNT_WIDTH-1:0];
    t_dec    = timer_q - TIME_WIDTH'(timer_q != '0);
    s_dec    = steps_q - COUNT_WIDTH'(steps_q != '0);
    ramp_ext = 33'(ramp_q);
    delta_ext = 33'(cfg_i.ramp_delta);
    r_down   = (ramp_ext > delta_ext) ? (ramp_ext - delta_ext) : 33'd0;
    r_up     = ramp_ext + delta_ext;
    case (phase_q)
      PH_ACCEL: ramp_upd = clamp_half(TIME_WIDTH'(r_down));
      PH_DECEL: ramp_upd = (r_up > TimeMax) ? {TIME_WIDTH{1'b1}} : TIME_WIDTH'(r_up);
      default:  ramp_upd = ramp_q;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    pin_d    = pin_q;
    dir_d    = dir_q;
    timer_d  = timer_q;
    ramp_d   = ramp_q;
    steps_d  = steps_q;
    cruise_d = cruise_q;
    done     = 1'b0;
    ignored  = 1'b0;
    do_enter = 1'b0;
    enter_ph = PH_IDLE;

    if (e_op == OP_START) begin
      if (phase_q != PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        dir_d    = e_dir;
        cruise_d = e_cruise;
        do_enter = 1'b1;
        enter_ph = (acc_sat != '0) ? PH_ACCEL :
                   (e_cruise != '0) ? PH_CRUISE : PH_IDLE;
      end
    end else if (phase_q != PH_IDLE) begin
      if (t_dec != '0) begin
        timer_d = t_dec;
      end else if (pin_q) begin
        pin_d   = 1'b0;
        timer_d = (phase_q == PH_CRUISE) ? clamp_time(cfg_i.cruise_low) : clamp_half(ramp_q);
      end else begin
        steps_d = s_dec;
        ramp_d  = ramp_upd;
        if (s_dec == '0) begin
          // Step count of this phase used up: move on, skipping empty phases
          do_enter = 1'b1;
          unique case (phase_q)
            PH_ACCEL:  enter_ph = (cruise_q != '0) ? PH_CRUISE :
                                  (acc_sat != '0) ? PH_DECEL : PH_IDLE;
            PH_CRUISE: enter_ph = (acc_sat != '0) ? PH_DECEL : PH_IDLE;
            default:   enter_ph = PH_IDLE;
          endcase
        end else begin
          pin_d   = 1'b1;
          timer_d = (phase_q == PH_CRUISE) ? clamp_time(cfg_i.cruise_high)
                                           : clamp_half(ramp_upd);
        end
      end
    end

    if (do_enter) begin
      phase_d = enter_ph;
      unique case (enter_ph)
        PH_IDLE: begin
          pin_d   = 1'b0;
          timer_d = '0;
          steps_d = '0;
          done    = 1'b1;
        end
        PH_CRUISE: begin
          pin_d   = 1'b1;
          steps_d = cruise_d;
          timer_d = clamp_time(cfg_i.cruise_high);
        end
        PH_ACCEL: begin
          pin_d   = 1'b1;
          steps_d = acc_sat;
          ramp_d  = clamp_time(cfg_i.ramp_start);
          timer_d = clamp_time(cfg_i.ramp_start);
        end
        default: begin
          pin_d   = 1'b1;
          steps_d = acc_sat;
          ramp_d  = clamp_time(cfg_i.ramp_end);
          timer_d = clamp_time(cfg_i.ramp_end);
        end
      endcase
    end

    res_d.step_level    = pin_d;
    res_d.dir_level     = dir_d;
    res_d.busy_res      = (phase_d != PH_IDLE);
    res_d.phase         = phase_d;
    res_d.move_done     = done;
    res_d.start_ignored = ignored;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pin_q       <= 1'b0;
      dir_q       <= 1'b0;
      timer_q     <= '0;
      ramp_q      <= '0;
      steps_q     <= '0;
      cruise_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q  <= phase_d;
        pin_q    <= pin_d;
        dir_q    <= dir_d;
        timer_q  <= timer_d;
        ramp_q   <= ramp_d;
        steps_q  <= steps_d;
        cruise_q <= cruise_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/stepper_trapezoid_pulse_gen_unit.sv @@
// Top level of the trapezoid step/direction generator: APB register bank,
// front end, command queue and back end. Depends on stpg_pkg and its submodules.
//
// Each input transfer is either one microsecond tick or a start command, and
// each produces exactly one result transfer with the pin levels and phase after
// it. The block sustains one transfer per clock on both sides while out_ready is
// high: the back end's profile update is combinational, and a two-entry queue
// plus the output register let the input keep flowing while a result waits,
// until the queue fills. With no backpressure a command passes through the queue
// and then the output register. There is no clearing pass after reset.
// Registers sit at byte addresses 0x00 to 0x14 and should only be written while
// no move is running and no transfer is in flight.
`default_nettype none

module stepper_trapezoid_pulse_gen_unit import stpg_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 24,
  parameter int unsigned TIME_WIDTH  = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                opcode_i,
  input  wire logic                direction_i,
  input  wire logic [TOTAL_W-1:0]  step_total_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     step_level_o,
  output logic                     dir_level_o,
  output logic                     busy_res_o,
  output logic [1:0]               phase_o,
  output logic                     move_done_o,
  output logic                     start_ignored_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned QW = COUNT_WIDTH + 2;

  stpg_cfg_t        cfg_q;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic             q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]    q_wdata, q_rdata;
  stpg_res_t        res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_steps <= RST_ACCEL_STEPS;
      cfg_q.ramp_start  <= RST_RAMP_START;
      cfg_q.ramp_end    <= RST_RAMP_END;
      cfg_q.ramp_delta  <= RST_RAMP_DELTA;
      cfg_q.cruise_high <= RST_CRUISE_HIGH;
      cfg_q.cruise_low  <= RST_CRUISE_LOW;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACCEL_STEPS: cfg_q.accel_steps <= pwdata[REG_W-1:0];
        REG_RAMP_START:  cfg_q.ramp_start  <= pwdata[REG_W-1:0];
        REG_RAMP_END:    cfg_q.ramp_end    <= pwdata[REG_W-1:0];
        REG_RAMP_DELTA:  cfg_q.ramp_delta  <= pwdata[DELTA_W-1:0];
        REG_CRUISE_HIGH: cfg_q.cruise_high <= pwdata[REG_W-1:0];
        REG_CRUISE_LOW:  cfg_q.cruise_low  <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCEL_STEPS: prdata = DATA_W'(cfg_q.accel_steps);
      REG_RAMP_START:  prdata = DATA_W'(cfg_q.ramp_start);
      REG_RAMP_END:    prdata = DATA_W'(cfg_q.ramp_end);
      REG_RAMP_DELTA:  prdata = DATA_W'(cfg_q.ramp_delta);
      REG_CRUISE_HIGH: prdata = DATA_W'(cfg_q.cruise_high);
      REG_CRUISE_LOW:  prdata = DATA_W'(cfg_q.cruise_low);
      default:         prdata = '0;
    endcase
  end

  stpg_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .direction_i  (direction_i),
    .step_total_i (step_total_i),
    .cfg_i        (cfg_q),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .q_full_i     (q_full)
  );

  stpg_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  stpg_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign step_level_o    = res.step_level;
  assign dir_level_o     = res.dir_level;
  assign busy_res_o      = res.busy_res;
  assign phase_o         = res.phase;
  assign move_done_o     = res.move_done;
  assign start_ignored_o = res.start_ignored;

endmodule

`default_nettype wire

@@ rtl/stpg_checker.sv @@
// Port-level checks for the trapezoid generator, bound to the top level.
// Depends on stpg_pkg for the phase codes.
`default_nettype none

module stpg_checker import stpg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic       step_level_i,
  input  wire logic       busy_res_i,
  input  wire logic [1:0] phase_i,
  input  wire logic       move_done_i,
  input  wire logic       start_ignored_i
);

  // Busy flag must track the phase code
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (busy_res_i == (phase_i != PH_IDLE)))
    else $error("busy_res disagrees with phase");

  // A finished move leaves the block idle with the step pin low
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && move_done_i) |-> (phase_i == PH_IDLE && !step_level_i))
    else $error("move_done without idle state");

  // A dropped start only happens while a move is running
  a_ignored_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && start_ignored_i) |-> (busy_res_i && !move_done_i))
    else $error("start dropped while idle");

  // Step pin is low whenever the block is idle
  a_idle_pin_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && phase_i == PH_IDLE) |-> !step_level_i)
    else $error("step pin high while idle");

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(phase_i) && $stable(step_level_i) && $stable(move_done_i)))
    else $error("result changed while stalled");

endmodule

bind stepper_trapezoid_pulse_gen_unit stpg_checker u_stpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .step_level_i    (step_level_o),
  .busy_res_i      (busy_res_o),
  .phase_i         (phase_o),
  .move_done_i     (move_done_o),
  .start_ignored_i (start_ignored_o)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for stepper_trapezoid_pulse_gen_unit: drives ticks and start
// commands, programs the profile over APB and checks every result against a cycle-free
// profile predictor. Depends on stpg_pkg and the RTL of the block only.

module testbench;
  import stpg_pkg::*;

  localparam int          SETTLE_CYCLES = 8;
  localparam longint      TIMEOUT_NS    = 64'd20_000_000;
  localparam logic [2:0]  REG_SPARE_A   = 3'd6;
  localparam logic [2:0]  REG_SPARE_B   = 3'd7;
  localparam logic [REG_W-1:0] HALF_MAX = {REG_W{1'b1}};

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  logic opcode;
  logic direction;
  logic [TOTAL_W-1:0] step_total;
  logic out_valid_o;
  logic out_ready;
  logic step_level_o;
  logic dir_level_o;
  logic busy_res_o;
  logic [1:0] phase_o;
  logic move_done_o;
  logic start_ignored_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  stepper_trapezoid_pulse_gen_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode),
    .direction_i    (direction),
    .step_total_i   (step_total),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .step_level_o   (step_level_o),
    .dir_level_o    (dir_level_o),
    .busy_res_o     (busy_res_o),
    .phase_o        (phase_o),
    .move_done_o    (move_done_o),
    .start_ignored_o(start_ignored_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Profile registers as the block should hold them
  stpg_cfg_t cfg;

  // Motion state of the predicted generator
  logic [1:0]         prof_phase;
  logic               prof_pin;
  logic               prof_dir;
  logic [REG_W-1:0]   half_tmr;
  logic [REG_W-1:0]   ramp_h;
  logic [TOTAL_W-1:0] steps_left;
  logic [TOTAL_W-1:0] cruise_len;

  stpg_res_t levels_due[$];

  logic tx_steady;
  logic rx_steady;
  int   items_sent;
  int   results_seen;
  int   moves_done;
  int   starts_dropped;
  int   mismatches;
  int   reg_errors;
  int   config_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [REG_W-1:0] clamp_half(input logic [REG_W-1:0] t);
    return (t == '0) ? {{(REG_W-1){1'b0}}, 1'b1} : t;
  endfunction

  function automatic logic [REG_W-1:0] half_for(input logic level);
    if (prof_phase == PH_CRUISE) return clamp_half(level ? cfg.cruise_high : cfg.cruise_low);
    return clamp_half(ramp_h);
  endfunction

  // Start the first non-empty phase from 'first' on; returns 1 when the move is over
  function automatic logic enter_phase(input logic [2:0] first);
    logic [2:0]         code;
    logic [TOTAL_W-1:0] n;
    logic               found;
    found = 1'b0;
    for (code = first; code <= 3'd3; code = code + 3'd1) begin
      if (!found) begin
        n = (code[1:0] == PH_CRUISE) ? cruise_len : {{(TOTAL_W-REG_W){1'b0}}, cfg.accel_steps};
        if (n != '0) begin
          found      = 1'b1;
          prof_phase = code[1:0];
          steps_left = n;
          if (code[1:0] == PH_ACCEL) ramp_h = clamp_half(cfg.ramp_start);
          else if (code[1:0] == PH_DECEL) ramp_h = clamp_half(cfg.ramp_end);
          prof_pin = 1'b1;
          half_tmr = half_for(1'b1);
        end
      end
    end
    if (!found) begin
      prof_phase = PH_IDLE;
      prof_pin   = 1'b0;
      half_tmr   = '0;
      steps_left = '0;
    end
    return !found;
  endfunction

  function automatic stpg_res_t advance_profile(input logic op, input logic dir,
                                                input logic [TOTAL_W-1:0] total);
    stpg_res_t        r;
    logic [TOTAL_W:0] twice;
    logic [REG_W:0]   grown;
    logic [REG_W-1:0] delta;
    logic             done;
    logic             ignored;
    done    = 1'b0;
    ignored = 1'b0;
    delta   = {{(REG_W-DELTA_W){1'b0}}, cfg.ramp_delta};
    if (op == OP_START) begin
      if (prof_phase != PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        twice      = {{(TOTAL_W-REG_W){1'b0}}, cfg.accel_steps, 1'b0};
        prof_dir   = dir;
        cruise_len = ({1'b0, total} > twice) ? total - twice[TOTAL_W-1:0] : '0;
        done       = enter_phase({1'b0, PH_ACCEL});
      end
    end else if (prof_phase != PH_IDLE) begin
      if (half_tmr != '0) half_tmr = half_tmr - 1'b1;
      if (half_tmr == '0) begin
        if (prof_pin) begin
          prof_pin = 1'b0;
          half_tmr = half_for(1'b0);
        end else begin
          if (steps_left != '0) steps_left = steps_left - 1'b1;
          if (prof_phase == PH_ACCEL) begin
            // shrinking half stops at one tick
            ramp_h = (ramp_h > delta) ? ramp_h - delta : {{(REG_W-1){1'b0}}, 1'b1};
          end else if (prof_phase == PH_DECEL) begin
            grown  = {1'b0, ramp_h} + {1'b0, delta};
            ramp_h = grown[REG_W] ? HALF_MAX : grown[REG_W-1:0];
          end
          if (steps_left == '0) begin
            done = enter_phase({1'b0, prof_phase} + 3'd1);
          end else begin
            prof_pin = 1'b1;
            half_tmr = half_for(1'b1);
          end
        end
      end
    end
    r.step_level    = prof_pin;
    r.dir_level     = prof_dir;
    r.busy_res      = (prof_phase != PH_IDLE);
    r.phase         = prof_phase;
    r.move_done     = done;
    r.start_ignored = ignored;
    return r;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_ACCEL_STEPS: cfg.accel_steps = data[REG_W-1:0];
      REG_RAMP_START:  cfg.ramp_start  = data[REG_W-1:0];
      REG_RAMP_END:    cfg.ramp_end    = data[REG_W-1:0];
      REG_RAMP_DELTA:  cfg.ramp_delta  = data[DELTA_W-1:0];
      REG_CRUISE_HIGH: cfg.cruise_high = data[REG_W-1:0];
      REG_CRUISE_LOW:  cfg.cruise_low  = data[REG_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] reg_word(input logic [2:0] idx);
    logic [DATA_W-1:0] w;
    w = '0;
    case (idx)
      REG_ACCEL_STEPS: w[REG_W-1:0]   = cfg.accel_steps;
      REG_RAMP_START:  w[REG_W-1:0]   = cfg.ramp_start;
      REG_RAMP_END:    w[REG_W-1:0]   = cfg.ramp_end;
      REG_RAMP_DELTA:  w[DELTA_W-1:0] = cfg.ramp_delta;
      REG_CRUISE_HIGH: w[REG_W-1:0]   = cfg.cruise_high;
      REG_CRUISE_LOW:  w[REG_W-1:0]   = cfg.cruise_low;
      default: ;
    endcase
    return w;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    store_reg(idx, data);
    config_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] idx);
    logic [DATA_W-1:0] want;
    want = reg_word(idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      if (mismatches + reg_errors < 10)
        $display("readback reg %0d: expected %h, got %h", idx, want, prdata);
      reg_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    apb_read_check(REG_ACCEL_STEPS);
    apb_read_check(REG_RAMP_START);
    apb_read_check(REG_RAMP_END);
    apb_read_check(REG_RAMP_DELTA);
    apb_read_check(REG_CRUISE_HIGH);
    apb_read_check(REG_CRUISE_LOW);
  endtask

  // Leaves valid high after the accepting edge; callers that pause use hold_input
  task automatic send_item(input logic op, input logic dir, input logic [TOTAL_W-1:0] total);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    direction  <= dir;
    step_total <= total;
    do @(posedge clk_i); while (!in_ready_o);
    levels_due.push_back(advance_profile(op, dir, total));
    items_sent++;
  endtask

  task automatic send_tick();
    logic [31:0] junk;
    junk = $urandom();
    send_item(OP_TICK, junk[31], junk[TOTAL_W-1:0]);
  endtask

  task automatic send_start(input logic dir, input logic [TOTAL_W-1:0] total);
    send_item(OP_START, dir, total);
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic finish_move();
    while (prof_phase != PH_IDLE) send_tick();
  endtask

  task automatic check_result();
    stpg_res_t got;
    stpg_res_t want;
    logic      bad;
    got = {step_level_o, dir_level_o, busy_res_o, phase_o, move_done_o, start_ignored_o};
    results_seen++;
    if (levels_due.size() == 0) begin
      if (mismatches + reg_errors < 10)
        $display("result %0d with nothing pending: %p", results_seen, got);
      mismatches++;
    end else begin
      want = levels_due.pop_front();
      bad  = (got.step_level !== want.step_level) || (got.dir_level !== want.dir_level) ||
             (got.busy_res !== want.busy_res) || (got.phase !== want.phase) ||
             (got.move_done !== want.move_done) || (got.start_ignored !== want.start_ignored);
      if (bad) begin
        if (mismatches + reg_errors < 10) begin
          $display("result %0d: expected step=%b dir=%b busy=%b phase=%0d done=%b ign=%b",
                   results_seen, want.step_level, want.dir_level, want.busy_res, want.phase,
                   want.move_done, want.start_ignored);
          $display("result %0d: got      step=%b dir=%b busy=%b phase=%0d done=%b ign=%b",
                   results_seen, got.step_level, got.dir_level, got.busy_res, got.phase,
                   got.move_done, got.start_ignored);
        end
        mismatches++;
      end
      if (want.move_done) moves_done++;
      if (want.start_ignored) starts_dropped++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) check_result();
  end

  // Result side: ready mostly high, random stalls unless told to stay steady
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] val, input int w);
    logic [DATA_W-1:0] r;
    r = $urandom();
    return (r & ~((32'd1 << w) - 1)) | (val & ((32'd1 << w) - 1));
  endfunction

  function automatic logic [REG_W-1:0] small_half(input int top);
    return ($urandom_range(0, 9) == 0) ? '0 : REG_W'($urandom_range(1, top));
  endfunction

  function automatic logic [TOTAL_W-1:0] pick_total();
    int a2;
    int r;
    a2 = 2 * int'(cfg.accel_steps);
    r  = $urandom_range(0, 9);
    if (r < 2) return TOTAL_W'($urandom_range(0, a2));
    if (r == 2) return TOTAL_W'(a2);
    return TOTAL_W'(a2 + $urandom_range(1, 10));
  endfunction

  task automatic test_register_access();
    logic [DATA_W-1:0] noise;
    read_all_regs();
    noise = $urandom();
    apb_write(REG_SPARE_A, noise);
    apb_write(REG_SPARE_B, ~noise);
    read_all_regs();
  endtask

  task automatic test_directed_moves();
    // tick with nothing running
    send_tick();
    hold_input();
    wait_drain();
    apb_write(REG_ACCEL_STEPS, 32'd0);
    apb_write(REG_CRUISE_HIGH, 32'd0);
    apb_write(REG_CRUISE_LOW, 32'd1);
    // every phase empty: done at once
    send_start(1'b1, '0);
    send_tick();
    // cruise only, with a dropped start in the middle
    send_start(1'b0, 24'd2);
    send_tick();
    send_start(1'b1, {TOTAL_W{1'b1}});
    finish_move();
    hold_input();
    wait_drain();
    apb_write(REG_ACCEL_STEPS, 32'd1);
    apb_write(REG_RAMP_START, 32'd2);
    apb_write(REG_RAMP_END, 32'd1);
    apb_write(REG_RAMP_DELTA, 32'd3);
    apb_write(REG_CRUISE_HIGH, 32'd1);
    // full trapezoid, ramp delta larger than the half
    send_start(1'b1, 24'd3);
    send_tick();
    send_tick();
    send_start(1'b0, 24'h5A5A5A);
    finish_move();
    // count below twice the ramp: empty cruise
    send_start(1'b0, 24'd1);
    finish_move();
    hold_input();
    wait_drain();
  endtask

  task automatic run_profile_phase(input int n_items);
    logic [DATA_W-1:0] v;
    v = $urandom_range(0, 6) == 0 ? 32'd0 : $urandom_range(1, 4);
    apb_write(REG_ACCEL_STEPS, with_junk(v, REG_W));
    apb_write(REG_RAMP_START, with_junk(small_half(10), REG_W));
    apb_write(REG_RAMP_END, with_junk(small_half(6), REG_W));
    case ($urandom_range(0, 9))
      0, 1:    v = 32'd0;
      2:       v = $urandom_range(5, 12);
      default: v = $urandom_range(1, 4);
    endcase
    apb_write(REG_RAMP_DELTA, with_junk(v, DELTA_W));
    apb_write(REG_CRUISE_HIGH, with_junk(small_half(5), REG_W));
    apb_write(REG_CRUISE_LOW, with_junk(small_half(5), REG_W));
    if ($urandom_range(0, 3) == 0) apb_write(REG_SPARE_A, $urandom());
    read_all_regs();
    for (int k = 0; k < n_items; k++) begin
      if (k % 97 == 50) begin
        // sender holds off until every result is back
        hold_input();
        wait_drain();
      end
      if (prof_phase == PH_IDLE) begin
        if ($urandom_range(0, 9) < 8) send_start($urandom_range(0, 1), pick_total());
        else send_tick();
      end else if ($urandom_range(0, 24) == 0) begin
        send_start($urandom_range(0, 1), TOTAL_W'($urandom()));
      end else begin
        send_tick();
      end
    end
    finish_move();
    hold_input();
    wait_drain();
  endtask

  task automatic test_random_profiles();
    for (int p = 0; p < 8; p++) begin
      tx_steady = (p == 1 || p == 5);
      rx_steady = (p == 2 || p == 5);
      run_profile_phase(235);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Every register at its top value; the move that follows cannot end within the run
  task automatic test_register_extremes();
    apb_write(REG_ACCEL_STEPS, {DATA_W{1'b1}});
    apb_write(REG_RAMP_START, {DATA_W{1'b1}});
    apb_write(REG_RAMP_END, {DATA_W{1'b1}});
    apb_write(REG_RAMP_DELTA, {DATA_W{1'b1}});
    apb_write(REG_CRUISE_HIGH, {DATA_W{1'b1}});
    apb_write(REG_CRUISE_LOW, {DATA_W{1'b1}});
    apb_write(REG_SPARE_B, {DATA_W{1'b1}});
    read_all_regs();
    send_start(1'b1, {TOTAL_W{1'b1}});
    for (int k = 0; k < 30; k++) begin
      if (k % 10 == 5) send_start($urandom_range(0, 1), TOTAL_W'($urandom()));
      else send_tick();
    end
    hold_input();
    wait_drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    opcode     = OP_TICK;
    direction  = 1'b0;
    step_total = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    items_sent = 0;
    results_seen = 0;
    moves_done = 0;
    starts_dropped = 0;
    mismatches = 0;
    reg_errors = 0;
    config_writes = 0;
    cfg.accel_steps = RST_ACCEL_STEPS;
    cfg.ramp_start  = RST_RAMP_START;
    cfg.ramp_end    = RST_RAMP_END;
    cfg.ramp_delta  = RST_RAMP_DELTA;
    cfg.cruise_high = RST_CRUISE_HIGH;
    cfg.cruise_low  = RST_CRUISE_LOW;
    prof_phase = PH_IDLE;
    prof_pin   = 1'b0;
    prof_dir   = 1'b0;
    half_tmr   = '0;
    ramp_h     = '0;
    steps_left = '0;
    cruise_len = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_directed_moves();
    test_random_profiles();
    test_register_extremes();

    $display("summary: %0d transfers in, %0d results checked, %0d moves, %0d starts dropped",
             items_sent, results_seen, moves_done, starts_dropped);
    $display("summary: %0d register writes over 11 profile settings, %0d readback errors",
             config_writes, reg_errors);
    if (mismatches == 0 && reg_errors == 0 && levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
